FILE: rtl/core/cpcf_pkg.sv
// ----------------------------------------------------------------------------
// cpcf_pkg
// Shared types and constants of the coin peak classifier and framer.
// ----------------------------------------------------------------------------
package cpcf_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int TOTAL_W   = 24;
  localparam int NUM_WIN   = 4;
  localparam int NUM_REGS  = 2 * NUM_WIN;
  localparam int REG_IDX_W = 4;
  localparam int WIN_IDX_W = 2;
  localparam int LEN_W     = 2;
  localparam int BIDX_W    = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFF_FFFF;

  // input kinds carried on in_tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_EDGE   = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_TEN_LOW          = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEN_HIGH         = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIFTY_LOW        = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_FIFTY_HIGH       = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_HUNDRED_LOW      = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_HUNDRED_HIGH     = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_FIVEHUNDRED_LOW  = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_FIVEHUNDRED_HIGH = 4'd7;

  // frame bytes
  localparam logic [7:0] CLASS_NONE   = 8'hED;
  localparam logic [7:0] BYTE_START   = 8'h53;
  localparam logic [7:0] OPCODE_MONEY = 8'h08;
  localparam logic [7:0] BYTE_END     = 8'h45;

  // position of a byte within the run
  localparam logic [BIDX_W-1:0] BI_CLASS  = 3'd0;
  localparam logic [BIDX_W-1:0] BI_START  = 3'd1;
  localparam logic [BIDX_W-1:0] BI_OPCODE = 3'd2;
  localparam logic [BIDX_W-1:0] BI_LEN    = 3'd3;
  localparam logic [BIDX_W-1:0] BI_TOT0   = 3'd4;
  localparam logic [BIDX_W-1:0] BI_TOT1   = 3'd5;
  localparam logic [BIDX_W-1:0] BI_TOT2   = 3'd6;

  typedef struct packed {
    logic [7:0]         cls;
    logic [TOTAL_W-1:0] total;
    logic [LEN_W-1:0]   len;
  } frame_t;

  function automatic logic [SAMPLE_W-1:0] reg_reset(input logic [REG_IDX_W-1:0] idx);
    logic [SAMPLE_W-1:0] v;
    case (idx)
      REG_TEN_LOW:          v = 10'd10;
      REG_TEN_HIGH:         v = 10'd30;
      REG_FIFTY_LOW:        v = 10'd100;
      REG_FIFTY_HIGH:       v = 10'd200;
      REG_HUNDRED_LOW:      v = 10'd400;
      REG_HUNDRED_HIGH:     v = 10'd470;
      REG_FIVEHUNDRED_LOW:  v = 10'd490;
      REG_FIVEHUNDRED_HIGH: v = 10'd550;
      default:              v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [TOTAL_W-1:0] coin_value(input logic [WIN_IDX_W-1:0] w);
    logic [TOTAL_W-1:0] v;
    case (w)
      2'd0:    v = 24'd10;
      2'd1:    v = 24'd50;
      2'd2:    v = 24'd100;
      2'd3:    v = 24'd500;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] coin_class(input logic [WIN_IDX_W-1:0] w);
    logic [7:0] v;
    case (w)
      2'd0:    v = 8'h44;
      2'd1:    v = 8'h55;
      2'd2:    v = 8'h66;
      2'd3:    v = 8'h77;
      default: v = CLASS_NONE;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/coin_peak_classifier_framer.sv
// ----------------------------------------------------------------------------
// coin_peak_classifier_framer
// Coin acceptor: peak tracking, window classification, running total and
// byte framing of each coin result.
// ----------------------------------------------------------------------------
// Throughput: one input item per cycle while the frame queue has room.
// A closing sensor edge's class byte passes the frame queue, then the output register.
// Each coin produces 6 to 8 output bytes, one per cycle while out_tready is high;
// up to QUEUE_DEPTH coin frames wait in the queue before in_tready drops.
// Reset (rst_n low, synchronous) clears peak, window, total, queue and
// output stage and restores the default window bounds.
module coin_peak_classifier_framer
  import cpcf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [9:0] sample, [15:10] zero
  input  logic                 in_tuser,   // [0] operation
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  logic   accept;
  logic   push, pop, head_valid, full;
  frame_t push_frame, head;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  cpcf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_tuser),
    .sample     (in_tdata[SAMPLE_W-1:0]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_frame (push_frame)
  );

  cpcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  cpcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready)
  );

endmodule

FILE: rtl/core/cpcf_front.sv
// ----------------------------------------------------------------------------
// cpcf_front
// Takes input items, tracks the peak, classifies on the closing edge, keeps
// the running total and pushes one frame request per coin.
// ----------------------------------------------------------------------------
module cpcf_front
  import cpcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 op,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  output logic                 push,
  output frame_t               push_frame
);

  logic [SAMPLE_W-1:0] regs_r [NUM_REGS];
  logic [SAMPLE_W-1:0] peak_r, peak_nxt;
  logic                sampling_r, sampling_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic [NUM_WIN-1:0]   match;
  logic [WIN_IDX_W-1:0] win;
  logic                 hit;
  logic [TOTAL_W:0]     sum;

  always_comb begin
    for (int i = 0; i < NUM_WIN; i++) begin
      match[i] = (peak_r > regs_r[2*i]) && (peak_r < regs_r[2*i+1]);
    end
    // lowest window wins on overlap
    win = '0;
    hit = 1'b0;
    for (int i = NUM_WIN - 1; i >= 0; i--) begin
      if (match[i]) begin
        win = WIN_IDX_W'(i);
        hit = 1'b1;
      end
    end
  end

  assign sum = {1'b0, total_r} + {1'b0, coin_value(win)};

  always_comb begin
    peak_nxt     = peak_r;
    sampling_nxt = sampling_r;
    total_nxt    = total_r;
    push         = 1'b0;
    if (accept) begin
      if (op == OP_SAMPLE) begin
        if (sampling_r && (sample > peak_r)) begin
          peak_nxt = sample;
        end
      end else if (peak_r == '0) begin
        sampling_nxt = 1'b1;
      end else begin
        push         = 1'b1;
        peak_nxt     = '0;
        sampling_nxt = 1'b0;
        if (hit) begin
          total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
      end
    end
  end

  always_comb begin
    push_frame.cls   = hit ? coin_class(win) : CLASS_NONE;
    push_frame.total = total_nxt;
    if (total_nxt[TOTAL_W-1:16] != '0) begin
      push_frame.len = 2'd3;
    end else if (total_nxt[15:8] != '0) begin
      push_frame.len = 2'd2;
    end else begin
      push_frame.len = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r     <= '0;
      sampling_r <= 1'b0;
      total_r    <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= reg_reset(REG_IDX_W'(i));
      end
    end else begin
      peak_r     <= peak_nxt;
      sampling_r <= sampling_nxt;
      total_r    <= total_nxt;
      if (cfg_we && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
        regs_r[cfg_index[WIN_IDX_W:0]] <= cfg_data;
      end
    end
  end

endmodule

FILE: rtl/core/cpcf_queue.sv
// ----------------------------------------------------------------------------
// cpcf_queue
// Small FIFO of frame requests between the front and the byte serializer.
// ----------------------------------------------------------------------------
module cpcf_queue
  import cpcf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_frame,
  input  logic   pop,
  output frame_t head,
  output logic   head_valid,
  output logic   full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("frame request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("frame request popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

FILE: rtl/core/cpcf_back.sv
// ----------------------------------------------------------------------------
// cpcf_back
// Serializes the head frame request into class byte and money frame, one
// byte per cycle while out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module cpcf_back
  import cpcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  frame_t     head,
  input  logic       head_valid,
  output logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_valid,
  input  logic       out_ready
);

  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [7:0]        byte_r;
  logic              last_r;
  logic              valid_r, valid_nxt;
  logic              load;
  logic              at_end;
  logic [7:0]        cur_byte;

  assign load   = head_valid && (!valid_r || out_ready);
  assign at_end = (bidx_r == BI_TOT0 + BIDX_W'(head.len));
  assign pop    = load && at_end;

  always_comb begin
    case (bidx_r)
      BI_CLASS:  cur_byte = head.cls;
      BI_START:  cur_byte = BYTE_START;
      BI_OPCODE: cur_byte = OPCODE_MONEY;
      BI_LEN:    cur_byte = {6'd0, head.len};
      BI_TOT0:   cur_byte = at_end ? BYTE_END : head.total[7:0];
      BI_TOT1:   cur_byte = at_end ? BYTE_END : head.total[15:8];
      BI_TOT2:   cur_byte = at_end ? BYTE_END : head.total[23:16];
      default:   cur_byte = BYTE_END;
    endcase
  end

  always_comb begin
    bidx_nxt  = bidx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      bidx_nxt  = at_end ? BI_CLASS : bidx_r + 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bidx_r  <= BI_CLASS;
      valid_r <= 1'b0;
    end else begin
      bidx_r  <= bidx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_valid = valid_r;

endmodule
